/* rtl/aff_pkg.sv */
// Shared types and constants for the affine point transform.
package aff_pkg;

   // Default widths and fixed-point format
   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 20;
   localparam int COEF_FRAC       = 16;
   localparam int OFFSET_HALF     = 32;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   // Register stages from input acceptance to the result register
   localparam int PIPE_DEPTH = 4;

   // Bit of the mode register that turns on measure passthrough
   localparam int MODE_MEASURE_BIT = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROW_X     = 3'd0,
      REG_ROW_Y     = 3'd1,
      REG_ROW_Z     = 3'd2,
      REG_PRE_XY    = 3'd3,
      REG_PRE_Z     = 3'd4,
      REG_POST_XY   = 3'd5,
      REG_POST_Z    = 3'd6,
      REG_MODE      = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_XY   = 2'd0,
      MODE_XYZ  = 2'd1,
      MODE_XYZM = 2'd2
   } vertex_mode_type;

   // Stage enables for one matrix row
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } row_ctl_type;

endpackage

/* rtl/aff_row.sv */
// One matrix row: registered products, then registered rounded dot product.
module aff_row #(
   parameter int COORD_WIDTH = aff_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = aff_pkg::COEF_WIDTH_DEF
) (
   input  logic                                        clock,
   input  aff_pkg::row_ctl_type                        ctl,
   input  logic                                        use_z,
   input  logic signed [COORD_WIDTH:0]                 diff_x,
   input  logic signed [COORD_WIDTH:0]                 diff_y,
   input  logic signed [COORD_WIDTH:0]                 diff_z,
   input  logic        [3*COEF_WIDTH-1:0]              coefs,
   output logic signed [COORD_WIDTH+COEF_WIDTH-14:0]   rounded
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = DW + COEF_WIDTH;
   localparam int AW = PW + 2;
   localparam int QW = AW - aff_pkg::COEF_FRAC;
   localparam logic signed [AW-1:0] ROUND_BIAS = AW'(2 ** (aff_pkg::COEF_FRAC - 1));

   logic signed [COEF_WIDTH-1:0] coef_x;
   logic signed [COEF_WIDTH-1:0] coef_y;
   logic signed [COEF_WIDTH-1:0] coef_z;
   logic signed [PW-1:0]         prod_x_in, prod_x_ff;
   logic signed [PW-1:0]         prod_y_in, prod_y_ff;
   logic signed [PW-1:0]         prod_z_raw;
   logic signed [PW-1:0]         prod_z_in, prod_z_ff;
   logic signed [AW-1:0]         acc;
   logic signed [QW-1:0]         rounded_in, rounded_ff;

   assign coef_x = coefs[COEF_WIDTH-1:0];
   assign coef_y = coefs[2*COEF_WIDTH-1:COEF_WIDTH];
   assign coef_z = coefs[3*COEF_WIDTH-1:2*COEF_WIDTH];

   // Multiply stage; the z term drops out in xy mode
   assign prod_x_in  = diff_x * coef_x;
   assign prod_y_in  = diff_y * coef_y;
   assign prod_z_raw = diff_z * coef_z;
   assign prod_z_in  = use_z ? prod_z_raw : '0;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // Sum stage: add half an LSB and drop the fraction (floor)
   assign acc = AW'(prod_x_ff) + AW'(prod_y_ff) + AW'(prod_z_ff) + ROUND_BIAS;
   assign rounded_in = acc[AW-1:aff_pkg::COEF_FRAC];

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         rounded_ff <= rounded_in;
      end
   end

   assign rounded = rounded_ff;

endmodule

/* rtl/aff_clip.sv */
// Output stage for one coordinate: post offset, saturation or passthrough.
module aff_clip #(
   parameter int COORD_WIDTH = aff_pkg::COORD_WIDTH_DEF,
   parameter int IN_WIDTH    = aff_pkg::COORD_WIDTH_DEF + aff_pkg::COEF_WIDTH_DEF - 13
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          pass,
   input  logic        [COORD_WIDTH-1:0] pass_value,
   input  logic signed [IN_WIDTH-1:0]    value,
   input  logic signed [COORD_WIDTH-1:0] offset,
   output logic        [COORD_WIDTH-1:0] result,
   output logic                          sat
);

   localparam int VW = ((IN_WIDTH > COORD_WIDTH) ? IN_WIDTH : COORD_WIDTH) + 1;
   localparam int HW = VW - COORD_WIDTH + 1;

   logic signed [VW-1:0]    sum;
   logic        [HW-1:0]    sum_top;
   logic                    over;
   logic [COORD_WIDTH-1:0]  limit;
   logic [COORD_WIDTH-1:0]  result_in, result_ff;
   logic                    sat_in, sat_ff;

   assign sum     = VW'(value) + VW'(offset);

   // Out of range when the sign bit and the bits above it disagree
   assign sum_top = sum[VW-1:COORD_WIDTH-1];
   assign over    = !((&sum_top) || (~|sum_top));
   assign limit   = sum[VW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(COORD_WIDTH-1){1'b1}}};

   assign result_in = pass ? pass_value : (over ? limit : sum[COORD_WIDTH-1:0]);
   assign sat_in    = !pass && over;

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

/* rtl/affine_point_transform.sv */
// Affine point transform: out = C * (in - pre) + post on a streaming vertex channel.
// Stages from request acceptance to response valid: pre-subtract, multiply, row sum and round,
// post-offset and saturate, one register each. Throughput: one vertex per cycle while
// responses are taken; a stalled response holds only as many stages as are full.
// Reset: synchronous, clears all stage valid bits and loads identity matrix, zero offsets,
// xy mode.
module affine_point_transform #(
   parameter int COORD_WIDTH = aff_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = aff_pkg::COEF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_z,
   input  logic signed [COORD_WIDTH-1:0]          req_measure,
   // Response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_WIDTH-1:0]          rsp_result_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_result_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_result_z,
   output logic signed [COORD_WIDTH-1:0]          rsp_result_measure,
   output logic                                   rsp_saturated,
   // Configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [aff_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [aff_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int RW   = 3 * COEF_WIDTH;
   localparam int DW   = COORD_WIDTH + 1;
   localparam int QW   = COORD_WIDTH + COEF_WIDTH - 13;
   localparam int HALF = (COORD_WIDTH < aff_pkg::OFFSET_HALF) ? COORD_WIDTH
                                                               : aff_pkg::OFFSET_HALF;
   localparam logic [63:0] ROW_X_RST = 64'd1 << aff_pkg::COEF_FRAC;
   localparam logic [63:0] ROW_Y_RST = 64'd1 << (aff_pkg::COEF_FRAC + COEF_WIDTH);
   localparam logic [63:0] ROW_Z_RST = 64'd1 << (aff_pkg::COEF_FRAC + 2 * COEF_WIDTH);

   // Configuration registers
   logic [RW-1:0] row_x_ff, row_y_ff, row_z_ff;
   logic [63:0]   pre_xy_ff, post_xy_ff;
   logic [31:0]   pre_z_ff, post_z_ff;
   logic [1:0]    vertex_mode_ff;

   // Pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;
   aff_pkg::row_ctl_type row_ctl;

   // Offsets widened to working widths
   logic signed [63:0]          pre_x_wide, pre_y_wide, pre_z_wide;
   logic signed [63:0]          post_x_wide, post_y_wide, post_z_wide;
   logic [63:0]                 pre_z_zext, post_z_zext;
   logic [COORD_WIDTH-1:0]      pre_z_c, post_z_c;

   // Stage 1: differences and sideband
   logic signed [DW-1:0]        diff_x_in, diff_y_in, diff_z_in;
   logic signed [DW-1:0]        diff_x_ff, diff_y_ff, diff_z_ff;
   logic                        xy_only_in;
   logic                        s1_xy_only_ff, s2_xy_only_ff, s3_xy_only_ff;
   logic [COORD_WIDTH-1:0]      measure_in;
   logic [COORD_WIDTH-1:0]      s1_z_ff, s2_z_ff, s3_z_ff;
   logic [COORD_WIDTH-1:0]      s1_measure_ff, s2_measure_ff, s3_measure_ff, s4_measure_ff;

   // Row results and output stage
   logic signed [QW-1:0]        rounded_x, rounded_y, rounded_z;
   logic [COORD_WIDTH-1:0]      out_x, out_y, out_z;
   logic                        sat_x, sat_y, sat_z;

   // Configuration writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff       <= ROW_X_RST[RW-1:0];
         row_y_ff       <= ROW_Y_RST[RW-1:0];
         row_z_ff       <= ROW_Z_RST[RW-1:0];
         pre_xy_ff      <= '0;
         pre_z_ff       <= '0;
         post_xy_ff     <= '0;
         post_z_ff      <= '0;
         vertex_mode_ff <= aff_pkg::MODE_XY;
      end else if (csr_valid) begin
         unique case (aff_pkg::csr_reg_type'(csr_index))
            aff_pkg::REG_ROW_X:   row_x_ff       <= csr_data[RW-1:0];
            aff_pkg::REG_ROW_Y:   row_y_ff       <= csr_data[RW-1:0];
            aff_pkg::REG_ROW_Z:   row_z_ff       <= csr_data[RW-1:0];
            aff_pkg::REG_PRE_XY:  pre_xy_ff      <= csr_data;
            aff_pkg::REG_PRE_Z:   pre_z_ff       <= csr_data[31:0];
            aff_pkg::REG_POST_XY: post_xy_ff     <= csr_data;
            aff_pkg::REG_POST_Z:  post_z_ff      <= csr_data[31:0];
            aff_pkg::REG_MODE:    vertex_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Stage enables: a stage moves when empty or when the next one moves
   assign s4_en     = !s4_valid_ff || rsp_ready;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   assign row_ctl.mul_en = s2_en;
   assign row_ctl.sum_en = s3_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   // xy offsets are signed halves; z offsets are 32-bit values read at coordinate width
   assign pre_x_wide  = 64'(signed'(pre_xy_ff[HALF-1:0]));
   assign pre_y_wide  = 64'(signed'(pre_xy_ff[32+HALF-1:32]));
   assign post_x_wide = 64'(signed'(post_xy_ff[HALF-1:0]));
   assign post_y_wide = 64'(signed'(post_xy_ff[32+HALF-1:32]));
   assign pre_z_zext  = {32'd0, pre_z_ff};
   assign post_z_zext = {32'd0, post_z_ff};
   assign pre_z_c     = pre_z_zext[COORD_WIDTH-1:0];
   assign post_z_c    = post_z_zext[COORD_WIDTH-1:0];
   assign pre_z_wide  = 64'(signed'(pre_z_c));
   assign post_z_wide = 64'(signed'(post_z_c));

   // Stage 1: subtract the pre offset
   assign diff_x_in  = {req_coord_x[COORD_WIDTH-1], req_coord_x} - pre_x_wide[DW-1:0];
   assign diff_y_in  = {req_coord_y[COORD_WIDTH-1], req_coord_y} - pre_y_wide[DW-1:0];
   assign diff_z_in  = {req_coord_z[COORD_WIDTH-1], req_coord_z} - pre_z_wide[DW-1:0];
   assign xy_only_in = (vertex_mode_ff == aff_pkg::MODE_XY);
   // mode three acts as xyzm
   assign measure_in = vertex_mode_ff[aff_pkg::MODE_MEASURE_BIT] ? req_measure : '0;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         diff_x_ff     <= diff_x_in;
         diff_y_ff     <= diff_y_in;
         diff_z_ff     <= diff_z_in;
         s1_xy_only_ff <= xy_only_in;
         s1_z_ff       <= req_coord_z;
         s1_measure_ff <= measure_in;
      end
   end

   // Sideband travels alongside the row stages
   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_xy_only_ff <= s1_xy_only_ff;
         s2_z_ff       <= s1_z_ff;
         s2_measure_ff <= s1_measure_ff;
      end
      if (s3_en) begin
         s3_xy_only_ff <= s2_xy_only_ff;
         s3_z_ff       <= s2_z_ff;
         s3_measure_ff <= s2_measure_ff;
      end
      if (s4_en) begin
         s4_measure_ff <= s3_measure_ff;
      end
   end

   // Stages 2 and 3: one row unit per output coordinate
   aff_row #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_row_x (
      .clock   (clock),
      .ctl     (row_ctl),
      .use_z   (!s1_xy_only_ff),
      .diff_x  (diff_x_ff),
      .diff_y  (diff_y_ff),
      .diff_z  (diff_z_ff),
      .coefs   (row_x_ff),
      .rounded (rounded_x)
   );

   aff_row #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_row_y (
      .clock   (clock),
      .ctl     (row_ctl),
      .use_z   (!s1_xy_only_ff),
      .diff_x  (diff_x_ff),
      .diff_y  (diff_y_ff),
      .diff_z  (diff_z_ff),
      .coefs   (row_y_ff),
      .rounded (rounded_y)
   );

   aff_row #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_row_z (
      .clock   (clock),
      .ctl     (row_ctl),
      .use_z   (1'b1),
      .diff_x  (diff_x_ff),
      .diff_y  (diff_y_ff),
      .diff_z  (diff_z_ff),
      .coefs   (row_z_ff),
      .rounded (rounded_z)
   );

   // Stage 4: post offset and saturation into the response register
   aff_clip #(.COORD_WIDTH(COORD_WIDTH), .IN_WIDTH(QW)) u_clip_x (
      .clock      (clock),
      .enable     (s4_en),
      .pass       (1'b0),
      .pass_value (s3_z_ff),
      .value      (rounded_x),
      .offset     (post_x_wide[COORD_WIDTH-1:0]),
      .result     (out_x),
      .sat        (sat_x)
   );

   aff_clip #(.COORD_WIDTH(COORD_WIDTH), .IN_WIDTH(QW)) u_clip_y (
      .clock      (clock),
      .enable     (s4_en),
      .pass       (1'b0),
      .pass_value (s3_z_ff),
      .value      (rounded_y),
      .offset     (post_y_wide[COORD_WIDTH-1:0]),
      .result     (out_y),
      .sat        (sat_y)
   );

   // z passes through untouched in xy mode
   aff_clip #(.COORD_WIDTH(COORD_WIDTH), .IN_WIDTH(QW)) u_clip_z (
      .clock      (clock),
      .enable     (s4_en),
      .pass       (s3_xy_only_ff),
      .pass_value (s3_z_ff),
      .value      (rounded_z),
      .offset     (post_z_wide[COORD_WIDTH-1:0]),
      .result     (out_z),
      .sat        (sat_z)
   );

   assign rsp_valid          = s4_valid_ff;
   assign rsp_result_x       = out_x;
   assign rsp_result_y       = out_y;
   assign rsp_result_z       = out_z;
   assign rsp_result_measure = s4_measure_ff;
   assign rsp_saturated      = sat_x || sat_y || sat_z;

endmodule

/* rtl/aff_chk.sv */
// Port-level checker for the affine point transform and its bind.
module aff_chk #(
   parameter int COORD_WIDTH = aff_pkg::COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_result_x,
   input logic [COORD_WIDTH-1:0] rsp_result_y,
   input logic [COORD_WIDTH-1:0] rsp_result_z,
   input logic [COORD_WIDTH-1:0] rsp_result_measure,
   input logic                   rsp_saturated
);

   logic [2:0] pending_in, pending_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Transactions accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_x)
         && $stable(rsp_result_y) && $stable(rsp_result_z)
         && $stable(rsp_result_measure) && $stable(rsp_saturated))
      else $error("stalled response changed");

   // With the output register empty the pipeline can always take a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while response register empty");

   // No response without an accepted request in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without pending request");

   // Never more in flight than there are stages
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'(aff_pkg::PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

endmodule

bind affine_point_transform aff_chk #(.COORD_WIDTH(COORD_WIDTH)) u_aff_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_x       (rsp_result_x),
   .rsp_result_y       (rsp_result_y),
   .rsp_result_z       (rsp_result_z),
   .rsp_result_measure (rsp_result_measure),
   .rsp_saturated      (rsp_saturated)
);

/* tb/sv/affine_point_transform_tb.sv */
// Self-checking testbench for the affine point transform: directed corners, then randomized streams.
`timescale 1ns / 1ps

module affine_point_transform_tb;

   localparam int CW             = aff_pkg::COORD_WIDTH_DEF;
   localparam int CFW            = aff_pkg::COEF_WIDTH_DEF;
   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 6;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 200;
   localparam int HOLDOFF_CYCLES = 80;

   // Mode value the block does not name; behaves like measure passthrough
   localparam logic [1:0] MODE_UNDEF = 2'd3;

   localparam logic [CFW-1:0] COEF_ZERO     = '0;
   localparam logic [CFW-1:0] COEF_ONE      = 20'h10000;
   localparam logic [CFW-1:0] COEF_HALF     = 20'h08000;
   localparam logic [CFW-1:0] COEF_NEG_HALF = 20'hF8000;
   localparam logic [CFW-1:0] COEF_MAX      = 20'h7FFFF;
   localparam logic [CFW-1:0] COEF_MIN      = 20'h80000;
   localparam logic [CW-1:0]  COORD_MAX     = 32'h7FFFFFFF;
   localparam logic [CW-1:0]  COORD_MIN     = 32'h80000000;

   typedef struct {
      logic signed [CW-1:0] x, y, z, m;
   } vertex_type;

   typedef struct {
      logic signed [CW-1:0] x, y, z, m;
      logic                 sat;
   } result_type;

   // Transform predictor with its own register copy, plus the queue of pending results
   class vertex_scoreboard;
      logic [3*CFW-1:0] row_coef [3];
      logic [63:0]      pre_xy, post_xy;
      logic [CW-1:0]    pre_z, post_z;
      logic [1:0]       mode;
      result_type       expected_vertices [$];
      int               mismatches;

      function new();
         row_coef[0] = (3*CFW)'(64'd1 << aff_pkg::COEF_FRAC);
         row_coef[1] = (3*CFW)'(64'd1 << (aff_pkg::COEF_FRAC + CFW));
         row_coef[2] = (3*CFW)'(64'd1 << (aff_pkg::COEF_FRAC + 2 * CFW));
         pre_xy      = '0;
         post_xy     = '0;
         pre_z       = '0;
         post_z      = '0;
         mode        = aff_pkg::MODE_XY;
         mismatches  = 0;
      endfunction

      function void write_reg(aff_pkg::csr_reg_type idx, logic [63:0] data);
         case (idx)
            aff_pkg::REG_ROW_X:   row_coef[0] = data[3*CFW-1:0];
            aff_pkg::REG_ROW_Y:   row_coef[1] = data[3*CFW-1:0];
            aff_pkg::REG_ROW_Z:   row_coef[2] = data[3*CFW-1:0];
            aff_pkg::REG_PRE_XY:  pre_xy      = data;
            aff_pkg::REG_PRE_Z:   pre_z       = data[CW-1:0];
            aff_pkg::REG_POST_XY: post_xy     = data;
            aff_pkg::REG_POST_Z:  post_z      = data[CW-1:0];
            aff_pkg::REG_MODE:    mode        = data[1:0];
            default: ;
         endcase
      endfunction

      // Exact dot product, rounded half up at the coefficient fraction
      function longint row_dot(logic [3*CFW-1:0] row, longint d [3], int terms);
         longint acc;
         acc = 0;
         for (int k = 0; k < terms; k++)
            acc += d[k] * longint'($signed(row[k*CFW +: CFW]));
         return (acc + (longint'(1) <<< (aff_pkg::COEF_FRAC - 1))) >>> aff_pkg::COEF_FRAC;
      endfunction

      function logic [CW-1:0] clip(longint v, inout bit sat);
         longint top;
         longint bottom;
         top    = (longint'(1) <<< (CW - 1)) - 1;
         bottom = -top - 1;
         if (v > top) begin
            v   = top;
            sat = 1'b1;
         end else if (v < bottom) begin
            v   = bottom;
            sat = 1'b1;
         end
         return v[CW-1:0];
      endfunction

      function result_type transform_vertex(vertex_type v);
         longint     d [3];
         result_type r;
         bit         sat;
         int         terms;
         sat   = 1'b0;
         terms = (mode == aff_pkg::MODE_XY) ? 2 : 3;
         d[0]  = longint'(v.x) - longint'($signed(pre_xy[aff_pkg::OFFSET_HALF-1:0]));
         d[1]  = longint'(v.y)
                 - longint'($signed(pre_xy[2*aff_pkg::OFFSET_HALF-1:aff_pkg::OFFSET_HALF]));
         d[2]  = longint'(v.z) - longint'($signed(pre_z));
         r.x = clip(row_dot(row_coef[0], d, terms)
                    + longint'($signed(post_xy[aff_pkg::OFFSET_HALF-1:0])), sat);
         r.y = clip(row_dot(row_coef[1], d, terms)
                    + longint'($signed(post_xy[2*aff_pkg::OFFSET_HALF-1:aff_pkg::OFFSET_HALF])),
                    sat);
         // xy mode leaves z untouched and cannot saturate on it
         if (mode == aff_pkg::MODE_XY)
            r.z = v.z;
         else
            r.z = clip(row_dot(row_coef[2], d, 3) + longint'($signed(post_z)), sat);
         r.m   = mode[aff_pkg::MODE_MEASURE_BIT] ? v.m : '0;
         r.sat = sat;
         return r;
      endfunction

      function void note_vertex(vertex_type v);
         expected_vertices.push_back(transform_vertex(v));
      endfunction

      function void check_vertex(result_type got);
         result_type want;
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result x=%0d y=%0d z=%0d m=%0d sat=%0b",
                        $time, got.x, got.y, got.z, got.m, got.sat);
            return;
         end
         want = expected_vertices.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
             got.m !== want.m || got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: mismatch expected x=%0d y=%0d z=%0d m=%0d sat=%0b,",
                         " got x=%0d y=%0d z=%0d m=%0d sat=%0b"},
                        $time, want.x, want.y, want.z, want.m, want.sat,
                        got.x, got.y, got.z, got.m, got.sat);
         end
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [CW-1:0]                req_coord_x = '0;
   logic signed [CW-1:0]                req_coord_y = '0;
   logic signed [CW-1:0]                req_coord_z = '0;
   logic signed [CW-1:0]                req_measure = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [CW-1:0]                rsp_result_x;
   logic signed [CW-1:0]                rsp_result_y;
   logic signed [CW-1:0]                rsp_result_z;
   logic signed [CW-1:0]                rsp_result_measure;
   logic                                rsp_saturated;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [aff_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [aff_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   vertex_scoreboard scoreboard = new();
   int               stall_pct = 0;
   int               rsp_holdoff = 0;

   affine_point_transform dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_measure        (req_measure),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_x       (rsp_result_x),
      .rsp_result_y       (rsp_result_y),
      .rsp_result_z       (rsp_result_z),
      .rsp_result_measure (rsp_result_measure),
      .rsp_saturated      (rsp_saturated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial forever #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic vertex_type vtx(logic [CW-1:0] x, y, z, m);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      v.m = m;
      return v;
   endfunction

   function automatic logic [63:0] pack_row(logic [CFW-1:0] cx, cy, cz, logic [3:0] spare);
      return {spare, cz, cy, cx};
   endfunction

   function automatic logic [63:0] pack_pair(logic [CW-1:0] x, y);
      return {y, x};
   endfunction

   function automatic logic [CFW-1:0] rand_coef();
      case ($urandom_range(7))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return COEF_ZERO;
         3, 4, 5: return CFW'($urandom_range(32'h40000) - 32'h20000);
         default: return CFW'($urandom);
      endcase
   endfunction

   // Many moderate coordinates so results are not all clipped
   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(9))
         0:          return COORD_MAX;
         1:          return COORD_MIN;
         2, 3, 4, 5: return $urandom_range(32'h200000) - 32'h100000;
         default:    return $urandom;
      endcase
   endfunction

   // Track every transaction on the three channels
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            scoreboard.write_reg(aff_pkg::csr_reg_type'(csr_index), csr_data);
         if (req_valid && req_ready)
            scoreboard.note_vertex(vtx(req_coord_x, req_coord_y, req_coord_z, req_measure));
         if (rsp_valid && rsp_ready) begin
            got.x   = rsp_result_x;
            got.y   = rsp_result_y;
            got.z   = rsp_result_z;
            got.m   = rsp_result_measure;
            got.sat = rsp_saturated;
            scoreboard.check_vertex(got);
         end
      end
   end

   // Response backpressure: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (rsp_holdoff > 0) begin
         rsp_ready <= 1'b0;
         rsp_holdoff--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_csr(aff_pkg::csr_reg_type idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_transform(logic [63:0] row_x, row_y, row_z, pre_xy, pre_z,
                                 post_xy, post_z, mode);
      write_csr(aff_pkg::REG_ROW_X, row_x);
      write_csr(aff_pkg::REG_ROW_Y, row_y);
      write_csr(aff_pkg::REG_ROW_Z, row_z);
      write_csr(aff_pkg::REG_PRE_XY, pre_xy);
      write_csr(aff_pkg::REG_PRE_Z, pre_z);
      write_csr(aff_pkg::REG_POST_XY, post_xy);
      write_csr(aff_pkg::REG_POST_Z, post_z);
      write_csr(aff_pkg::REG_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   // Offer vertices back to back, with random idle cycles in between
   task automatic drive_vertices(vertex_type items [$], int idle_pct);
      int gap;
      foreach (items[i]) begin
         gap = 0;
         while ($urandom_range(99) < idle_pct) gap++;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_coord_x <= items[i].x;
         req_coord_y <= items[i].y;
         req_coord_z <= items[i].z;
         req_measure <= items[i].m;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   initial begin
      vertex_type     items [$];
      logic [CFW-1:0] c [9];
      logic [1:0]     mode_cycle [4];
      int             send_idle [4];
      int             rsp_stall [4];
      logic [63:0]    mode_word;

      mode_cycle = '{aff_pkg::MODE_XY, aff_pkg::MODE_XYZ, aff_pkg::MODE_XYZM, MODE_UNDEF};
      send_idle  = '{0, 50, 0, 16};
      rsp_stall  = '{0, 0, 50, 16};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state: identity matrix, zero offsets, xy mode
      items.push_back(vtx(0, 0, 0, 0));
      items.push_back(vtx(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
      items.push_back(vtx(COORD_MIN, COORD_MAX, -1, COORD_MAX));
      items.push_back(vtx(-1, 1, 32'h12345678, -7));
      drive_vertices(items, 0);
      wait_drained();
      items.delete();

      // Extreme coefficients and offsets: saturation both ways, measure passthrough
      load_transform(pack_row(COEF_MAX, COEF_MAX, COEF_MAX, 4'h0),
                     pack_row(COEF_MIN, COEF_MIN, COEF_MIN, 4'h0),
                     pack_row(COEF_ONE, COEF_MIN, COEF_MAX, 4'h0),
                     pack_pair(COORD_MAX, COORD_MIN), {32'd0, COORD_MAX},
                     pack_pair(COORD_MIN, COORD_MAX), {32'd0, COORD_MIN},
                     {62'd0, aff_pkg::MODE_XYZM});
      items.push_back(vtx(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
      items.push_back(vtx(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN));
      items.push_back(vtx(0, 0, 0, -1));
      items.push_back(vtx(1, -1, 2, 32'h5A5A5A5A));
      drive_vertices(items, 0);
      wait_drained();
      items.delete();

      // Half-LSB ties round toward plus infinity; undefined mode acts as xyzm
      load_transform(pack_row(COEF_HALF, COEF_ZERO, COEF_ZERO, 4'h0),
                     pack_row(COEF_ZERO, COEF_NEG_HALF, COEF_ZERO, 4'h0),
                     pack_row(COEF_HALF, COEF_HALF, COEF_HALF, 4'h0),
                     64'd0, 64'd0, 64'd0, 64'd0, {62'd0, MODE_UNDEF});
      items.push_back(vtx(1, 1, 1, 3));
      items.push_back(vtx(-1, -1, -1, -3));
      items.push_back(vtx(3, -3, 0, COORD_MAX));
      drive_vertices(items, 0);
      wait_drained();
      items.delete();

      // xyz mode without measure
      load_transform(pack_row(COEF_ONE, COEF_ONE, COEF_ONE, 4'h0),
                     pack_row(COEF_MIN, COEF_MIN, COEF_MIN, 4'h0),
                     pack_row(COEF_MAX, COEF_ZERO, COEF_MIN, 4'h0),
                     64'd0, 64'd0, 64'd0, 64'd0, {62'd0, aff_pkg::MODE_XYZ});
      items.push_back(vtx(COORD_MAX, COORD_MAX, COORD_MAX, 77));
      items.push_back(vtx(COORD_MIN, COORD_MIN, COORD_MIN, -77));
      drive_vertices(items, 0);
      wait_drained();
      items.delete();

      // xy mode ignores row z, z offsets and the z column of rows x and y
      load_transform(pack_row(COEF_ONE, COEF_ZERO, COEF_MAX, 4'h0),
                     pack_row(COEF_ZERO, COEF_ONE, COEF_MAX, 4'h0),
                     pack_row(COEF_MAX, COEF_MAX, COEF_MAX, 4'h0),
                     64'd0, {32'd0, COORD_MAX}, 64'd0, {32'd0, COORD_MIN},
                     {62'd0, aff_pkg::MODE_XY});
      items.push_back(vtx(5, 6, COORD_MIN, 9));
      items.push_back(vtx(COORD_MAX, COORD_MIN, COORD_MAX, 1));
      drive_vertices(items, 0);
      wait_drained();
      items.delete();

      // Random phases: new transform each phase, varying idle and stall patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int k = 0; k < 9; k++)
            c[k] = (p == 0) ? COEF_MAX : (p == 1) ? COEF_MIN : rand_coef();
         mode_word      = {$urandom, $urandom};
         mode_word[1:0] = mode_cycle[(p + p / 4) % 4];
         load_transform(pack_row(c[0], c[1], c[2], 4'($urandom)),
                        pack_row(c[3], c[4], c[5], 4'($urandom)),
                        pack_row(c[6], c[7], c[8], 4'($urandom)),
                        pack_pair(rand_coord(), rand_coord()), {$urandom, rand_coord()},
                        pack_pair(rand_coord(), rand_coord()), {$urandom, rand_coord()},
                        mode_word);
         for (int i = 0; i < PHASE_ITEMS; i++)
            items.push_back(vtx(rand_coord(), rand_coord(), rand_coord(), $urandom));
         stall_pct = rsp_stall[p % 4];
         // Hold the response side off so the pipeline fills and stalls the input
         if (p % 4 == 0)
            rsp_holdoff = HOLDOFF_CYCLES;
         drive_vertices(items, send_idle[p % 4]);
         wait_drained();
         items.delete();
      end

      stall_pct = 0;
      repeat (aff_pkg::PIPE_DEPTH * 4) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("affine_point_transform_tb OK");
      else
         $display("affine_point_transform_tb NOT OK");
      $finish;
   end

   // Run limit
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("affine_point_transform_tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
rtl/aff_pkg.sv
rtl/aff_row.sv
rtl/aff_clip.sv
rtl/affine_point_transform.sv
rtl/aff_chk.sv
tb/sv/affine_point_transform_tb.sv
